// ===== src/imf_pkg.sv =====
// Shared constants for the inertial sensor frame decoder.
package imf_pkg;

   localparam int unsigned FrameLen = 11;

   localparam logic [3:0] PosHeader   = 4'd0;
   localparam logic [3:0] PosType     = 4'd1;
   localparam logic [3:0] PosChecksum = 4'(FrameLen - 1);

   localparam logic [7:0] HeaderByte = 8'h55;
   localparam logic [7:0] TypeAccel  = 8'h51;
   localparam logic [7:0] TypeGyro   = 8'h52;
   localparam logic [7:0] TypeAngle  = 8'h53;

   localparam logic [1:0] KindAccel = 2'd0;
   localparam logic [1:0] KindGyro  = 2'd1;
   localparam logic [1:0] KindAngle = 2'd2;

   localparam logic signed [22:0] MulAccelGyro = 23'sd125;
   localparam logic signed [22:0] MulAngle     = 23'sd45;

   typedef logic signed [22:0] value_type;
   typedef logic signed [15:0] word_type;

endpackage

// ===== src/imu_frame_decoder.sv =====
// Inertial sensor serial frame decoder: 11-byte frames to scaled fixed-point results.
//
//  channel | dir | ports                                         | handshake
//  --------+-----+-----------------------------------------------+-------------------
//  req     | in  | req_data_byte[7:0], req_burst_start           | req_valid/req_stall
//  rsp     | out | rsp_frame_kind[1:0], rsp_value_x/y/z[22:0],   | rsp_valid/rsp_stall
//          |     | rsp_value_extra[15:0]                         |
//
// One byte per cycle unless rsp stalls. A request is registered, then decoded when
// taken; rsp_valid rises in the cycle after a good frame's checksum byte is taken.
// Synchronous reset clears frame position, checksum, header flag and valids.
// A stalled result holds in the output register and stalls req once the input
// register holds a byte.
module imu_frame_decoder
   import imf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_burst_start,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_frame_kind,
   output logic signed [22:0] rsp_value_x,
   output logic signed [22:0] rsp_value_y,
   output logic signed [22:0] rsp_value_z,
   output logic signed [15:0] rsp_value_extra
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_burst_ff, in_burst_in;

   logic [3:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic       hdr_ff, hdr_in;
   logic [7:0] type_ff;
   logic [7:0] payload_ff [8];

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff, kind_in;
   value_type  x_ff, x_in, y_ff, y_in, z_ff, z_in;
   word_type   extra_ff, extra_in;

   logic       advance, take, load, type_ok;
   logic [3:0] pos_cur, pos_raw;
   logic [2:0] pay_idx;
   word_type   w0, w1, w2, w3;
   value_type  mul;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign take      = in_valid_ff && advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_burst_in = in_burst_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
         in_burst_in = req_burst_start;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   assign pos_raw = in_burst_ff ? PosHeader : pos_ff;
   assign pos_cur = (pos_raw > PosChecksum) ? PosHeader : pos_raw;
   assign pay_idx = 3'(pos_cur - 4'd2);

   assign w0 = word_type'({payload_ff[1], payload_ff[0]});
   assign w1 = word_type'({payload_ff[3], payload_ff[2]});
   assign w2 = word_type'({payload_ff[5], payload_ff[4]});
   assign w3 = word_type'({payload_ff[7], payload_ff[6]});

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      hdr_in   = hdr_ff;
      load     = 1'b0;
      type_ok  = 1'b1;
      kind_in  = kind_ff;
      extra_in = extra_ff;
      mul      = MulAccelGyro;
      case (type_ff)
         TypeAccel: begin
            kind_in  = KindAccel;
            extra_in = w3;
         end
         TypeGyro: begin
            kind_in  = KindGyro;
            extra_in = '0;
         end
         TypeAngle: begin
            kind_in  = KindAngle;
            extra_in = w3;
            mul      = MulAngle;
         end
         default: begin
            type_ok = 1'b0;
         end
      endcase
      x_in = value_type'(w0) * mul;
      y_in = value_type'(w1) * mul;
      z_in = value_type'(w2) * mul;
      if (take) begin
         if (pos_cur == PosChecksum) begin
            pos_in = PosHeader;
            load   = hdr_ff && (sum_ff == in_byte_ff) && type_ok;
         end else begin
            pos_in = pos_cur + 4'd1;
            if (pos_cur == PosHeader) begin
               hdr_in = (in_byte_ff == HeaderByte);
               sum_in = in_byte_ff;
            end else begin
               sum_in = sum_ff + in_byte_ff;
            end
         end
      end
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pos_ff       <= PosHeader;
         sum_ff       <= '0;
         hdr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         hdr_ff       <= hdr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_burst_ff <= in_burst_in;
      if (take && pos_cur == PosType) begin
         type_ff <= in_byte_ff;
      end
      if (take && pos_cur != PosHeader && pos_cur != PosType && pos_cur != PosChecksum) begin
         payload_ff[pay_idx] <= in_byte_ff;
      end
      if (load) begin
         kind_ff  <= kind_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         extra_ff <= extra_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_kind  = kind_ff;
   assign rsp_value_x     = x_ff;
   assign rsp_value_y     = y_ff;
   assign rsp_value_z     = z_ff;
   assign rsp_value_extra = extra_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosChecksum)
      else $error("frame position out of range");

   a_load_on_checksum: assert property (@(posedge clock) disable iff (reset)
      load |-> take && pos_cur == PosChecksum && hdr_ff)
      else $error("result loaded off a checksum byte");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> kind_ff == KindAccel || kind_ff == KindGyro || kind_ff == KindAngle)
      else $error("illegal frame kind");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !load)
      else $error("stalled result overwritten");

   a_pos_wrap: assert property (@(posedge clock) disable iff (reset)
      take && pos_cur == PosChecksum |=> pos_ff == PosHeader)
      else $error("frame position did not wrap after checksum");

endmodule
